// ===== sv/hmvc_pkg.sv =====
// Package for the horizon mask visibility check: field widths, request and
// result types, configuration register indexes. No dependencies.
package hmvc_pkg;

    // Storage depth default and fixed field widths
    localparam int MASK_DEPTH_DEF = 32;
    localparam int AZ_W           = 17;
    localparam int EL_W           = 16;
    localparam int RANGE_W        = 32;
    localparam int IDX_W          = 5;
    localparam int COUNT_W        = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    // Shared multiplier: 18 x 18 signed operands
    localparam int MUL_W          = AZ_W + 1;
    localparam int PROD_W         = 2 * MUL_W;

    // Request commands
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_e;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MIN = 2'd0,
        REG_RANGE_MAX = 2'd1,
        REG_BP_COUNT  = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic                   command;
        logic [IDX_W-1:0]       entry_index;
        logic [AZ_W-1:0]        azimuth;
        logic signed [EL_W-1:0] elevation;
        logic [RANGE_W-1:0]     range_m;
    } in_item_t;

    typedef struct packed {
        logic satisfied;
    } out_item_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_min_m;
        logic [RANGE_W-1:0] range_max_m;
        logic [COUNT_W-1:0] breakpoint_count;
    } cfg_t;

    // One mask breakpoint as stored in the RAM
    typedef struct packed {
        logic [AZ_W-1:0]        az;
        logic signed [EL_W-1:0] el;
    } mask_entry_t;

endpackage

// ===== sv/hmvc_if.sv =====
// Channel interfaces for the horizon mask visibility check: a valid/ready
// stream with a typed payload and the configuration write channel. Uses hmvc_pkg.
interface hmvc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hmvc_cfg_if
    import hmvc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/hmvc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hmvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/hmvc_mul.sv =====
// Shared signed multiplier with a registered product, used for both terms
// of the cross product. Uses hmvc_pkg.
module hmvc_mul
    import hmvc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/hmvc_cfg_regs.sv =====
// Configuration registers: range interval bounds and breakpoint count.
// Uses hmvc_pkg and hmvc_cfg_if.
module hmvc_cfg_regs
    import hmvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hmvc_cfg_if.sink    cfg,
    output cfg_t        cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RANGE_MIN: cfg_next.range_min_m      = cfg.data;
                REG_RANGE_MAX: cfg_next.range_max_m      = cfg.data;
                REG_BP_COUNT:  cfg_next.breakpoint_count = cfg.data[COUNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min_m      <= '0;
            cfg_reg.range_max_m      <= '1;
            cfg_reg.breakpoint_count <= COUNT_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/horizon_mask_visibility_check.sv =====
// Horizon mask visibility check: top level with the walk/cross-product sequencer.
// Uses hmvc_pkg, hmvc_if, hmvc_ram, hmvc_mul and hmvc_cfg_regs.
//
// Usage:
//   item   - request stream. A load request (command 0) writes one breakpoint
//            to slot entry_index; the block stays ready.
//            A test request (command 1) produces one result.
//   result - one satisfied bit per test request, held in an output register.
//   cfg    - register writes (range_min_m, range_max_m, breakpoint_count),
//            always ready; write only while no test is in progress.
// Sequence: a test request keeps the block busy, N being the breakpoint
//   count clamped to [2, MASK_DEPTH]. The mask RAM is read one breakpoint per
//   cycle (N - 1 segment starts plus the segment end), then the shared
//   multiplier forms the two cross-product terms in turn.
// Throughput: no new request is taken until the test is through and the
//   block is back in idle; loads one per cycle while idle.
// Stall: a finished result waits in the output register; the block takes
//   new requests meanwhile, and a second test holds in its last step until
//   the first result has been taken.
// Reset: control and configuration registers return to their reset values;
//   datapath registers are not reset; mask contents are undefined until loaded.
module horizon_mask_visibility_check
    import hmvc_pkg::*;
#(
    parameter int MASK_DEPTH = MASK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hmvc_stream_if.sink   item,
    hmvc_stream_if.source result,
    hmvc_cfg_if.sink      cfg
);

    localparam int AW = $clog2(MASK_DEPTH);
    localparam int CW = ($clog2(MASK_DEPTH + 1) > COUNT_W) ? $clog2(MASK_DEPTH + 1) : COUNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_DIFF  = 7'b0001000,
        S_MUL1  = 7'b0010000,
        S_MUL2  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    cfg_t        cfg_q;
    mask_entry_t wr_entry;
    mask_entry_t rd_entry;
    logic [$bits(mask_entry_t)-1:0] rd_data;

    state_t         state_reg, state_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  didx_reg, didx_next;
    logic [AW-1:0]  last_reg, last_next;
    logic [AW-1:0]  lo_reg, lo_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_sat_reg, out_sat_next;

    logic [AZ_W-1:0]          az_reg;
    logic signed [EL_W-1:0]   el_reg;
    logic [RANGE_W-1:0]       range_reg;
    logic [AZ_W-1:0]          lo_az_reg;
    logic signed [EL_W-1:0]   lo_el_reg;
    logic signed [MUL_W-1:0]  dx_reg, dy_reg, px_reg, py_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    logic [CW-1:0]  cnt_ext, used_cnt;
    logic [AW-1:0]  last_start;
    logic           accept, test_accept, load_ok, wr_en, hit;
    logic           above, range_ok;

    hmvc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Mask storage: one write per load request, one read per sequencer step
    assign load_ok        = (32'(item.data.entry_index) < 32'(MASK_DEPTH));
    assign accept         = item.valid && item.ready;
    assign test_accept    = accept && (item.data.command == CMD_TEST);
    assign wr_en          = accept && (item.data.command == CMD_LOAD) && load_ok;
    assign wr_entry.az    = item.data.azimuth;
    assign wr_entry.el    = item.data.elevation;
    assign rd_entry       = mask_entry_t'(rd_data);

    hmvc_ram #(
        .WIDTH ($bits(mask_entry_t)),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(item.data.entry_index)),
        .wr_data (wr_entry),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Shared multiplier: dx*py, then dy*px
    assign mul_a = (state_reg == S_MUL1) ? dx_reg : dy_reg;
    assign mul_b = (state_reg == S_MUL1) ? py_reg : px_reg;

    hmvc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Breakpoint count clamped to [2, MASK_DEPTH]; last segment start index
    always_comb
    begin
        cnt_ext = CW'(cfg_q.breakpoint_count);
        if (cnt_ext < CW'(2))
        begin
            used_cnt = CW'(2);
        end
        else if (cnt_ext > CW'(MASK_DEPTH))
        begin
            used_cnt = CW'(MASK_DEPTH);
        end
        else
        begin
            used_cnt = cnt_ext;
        end
        last_start = AW'(used_cnt - CW'(2));
    end

    // Segment start test for the breakpoint now on the read port
    assign hit      = pend_reg && ((didx_reg == '0) || (rd_entry.az <= az_reg));
    assign above    = (p1_reg >= prod);
    assign range_ok = (range_reg >= cfg_q.range_min_m) && (range_reg <= cfg_q.range_max_m);

    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.data.satisfied = out_sat_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        didx_next      = didx_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (test_accept)
                begin
                    state_next = S_WALK;
                    addr_next  = '0;
                    pend_next  = 1'b0;
                    last_next  = last_start;
                    lo_next    = '0;
                end
            end
            S_WALK:
            begin
                // issue the next segment start
                if (addr_reg <= last_reg)
                begin
                    addr_next = addr_reg + AW'(1);
                    pend_next = 1'b1;
                    didx_next = addr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // check the returned one
                if (hit)
                begin
                    lo_next = didx_reg;
                end
                if (pend_reg && (didx_reg == last_reg))
                begin
                    addr_next  = lo_next + AW'(1);
                    pend_next  = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sat_next   = above && range_ok;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            didx_reg      <= '0;
            last_reg      <= '0;
            lo_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            didx_reg      <= didx_next;
            last_reg      <= last_next;
            lo_reg        <= lo_next;
            out_valid_reg <= out_valid_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (test_accept)
        begin
            az_reg    <= item.data.azimuth;
            el_reg    <= item.data.elevation;
            range_reg <= item.data.range_m;
        end
        if ((state_reg == S_WALK) && hit)
        begin
            lo_az_reg <= rd_entry.az;
            lo_el_reg <= rd_entry.el;
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= signed'(MUL_W'(rd_entry.az)) - signed'(MUL_W'(lo_az_reg));
            dy_reg <= MUL_W'(rd_entry.el) - MUL_W'(lo_el_reg);
            px_reg <= signed'(MUL_W'(az_reg)) - signed'(MUL_W'(lo_az_reg));
            py_reg <= MUL_W'(el_reg) - MUL_W'(lo_el_reg);
        end
        if (state_reg == S_MUL2)
        begin
            p1_reg <= prod;
        end
    end

endmodule

// ===== sv/hmvc_checker.sv =====
// Port-level checker for the horizon mask visibility check, bound to the top.
// Uses hmvc_pkg.
module hmvc_checker
    import hmvc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_command,
    input logic out_valid,
    input logic out_ready,
    input logic out_satisfied
);

    // A test request occupies the sequencer
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_TEST) |=> !in_ready)
        else $error("ready high right after a test request");

    // A load request leaves the block ready
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_LOAD) |=> in_ready)
        else $error("ready dropped after a load request");

    // A new result is posted as the sequencer returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while sequencer busy");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_satisfied))
        else $error("stalled result changed");

endmodule

bind horizon_mask_visibility_check hmvc_checker u_hmvc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .in_command    (item.data.command),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_satisfied (result.data.satisfied)
);

// ===== verif/horizon_mask_visibility_check_tb.sv =====
// Self-checking testbench for horizon_mask_visibility_check: loads masks, tests points,
// checks each satisfied bit against an in-bench prediction of the mask and range tests.
// Depends on hmvc_pkg, hmvc_if and the horizon_mask_visibility_check RTL.
module horizon_mask_visibility_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmvc_pkg::*;

    localparam int                   DEPTH          = MASK_DEPTH_DEF;
    localparam int                   FULL_TURN      = 65536;
    localparam int                   SETTLE_CYCLES  = 45;   // covers a test's busy time, N <= 32
    localparam int                   RANDOM_PHASES  = 12;
    localparam int                   PHASE_REQUESTS = 130;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hmvc_stream_if #(.T(in_item_t))  item_ch ();
    hmvc_stream_if #(.T(out_item_t)) result_ch ();
    hmvc_cfg_if                      cfg_ch ();

    horizon_mask_visibility_check DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    // Requests waiting for the driver, verdicts waiting for the monitor
    in_item_t  queued_requests[$];
    out_item_t expected_verdicts[$];

    // Shadow of the block: registers and mask table
    logic [RANGE_W-1:0]     cur_range_min;
    logic [RANGE_W-1:0]     cur_range_max;
    logic [COUNT_W-1:0]     cur_bp_count;
    logic [AZ_W-1:0]        mask_az [DEPTH];
    logic signed [EL_W-1:0] mask_el [DEPTH];

    // Mask the stimulus currently aims at
    int plan_az [DEPTH];
    int plan_el [DEPTH];
    int plan_n;

    bit gaps_on;
    int send_gap;
    int stall_left;
    int mismatch_count;

    task automatic report_mismatch(string msg);
        if (mismatch_count < 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Apply one accepted request to the shadow; a test request yields one verdict
    function automatic void predict_visibility(in_item_t req);
        int        n;
        int        lo;
        longint    dx;
        longint    dy;
        longint    px;
        longint    py;
        bit        above;
        out_item_t verdict;
        if (req.command == CMD_LOAD) begin
            mask_az[req.entry_index] = req.azimuth;
            mask_el[req.entry_index] = req.elevation;
        end else begin
            n = int'(cur_bp_count);
            if (n < 2)
                n = 2;
            if (n > DEPTH)
                n = DEPTH;
            // last segment start at or below the point, never the final entry
            lo = 0;
            for (int i = 0; i + 1 < n; i++)
                if (mask_az[i] <= req.azimuth)
                    lo = i;
            dx = longint'(mask_az[lo + 1]) - longint'(mask_az[lo]);
            dy = longint'(mask_el[lo + 1]) - longint'(mask_el[lo]);
            px = longint'(req.azimuth) - longint'(mask_az[lo]);
            py = longint'($signed(req.elevation)) - longint'(mask_el[lo]);
            above = (dx * py - dy * px) >= 0;
            verdict.satisfied = above && (req.range_m >= cur_range_min)
                                && (req.range_m <= cur_range_max);
            expected_verdicts.push_back(verdict);
        end
    endfunction

    // Request driver with random gap bursts
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            send_gap = 0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                predict_visibility(item_ch.data);
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    item_ch.data  <= queued_requests.pop_front();
                    item_ch.valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 16);
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stall bursts
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        out_item_t got;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result %b with no test pending", got.satisfied));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.satisfied !== want.satisfied)
                        report_mismatch($sformatf("satisfied %b, expected %b",
                                                  got.satisfied, want.satisfied));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Register write; caller is at a rising edge and lowers valid after the last one
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_RANGE_MIN: cur_range_min = val;
            REG_RANGE_MAX: cur_range_max = val;
            REG_BP_COUNT:  cur_bp_count  = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [31:0] rmin, logic [31:0] rmax, logic [31:0] count);
        write_register(REG_RANGE_MIN, rmin);
        write_register(REG_RANGE_MAX, rmax);
        write_register(REG_BP_COUNT, count);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold off until every request has gone and every verdict has come back
    task automatic drain_requests();
        do @(negedge clk);
        while (queued_requests.size() != 0 || item_ch.valid || expected_verdicts.size() != 0);
    endtask

    function automatic void push_load(int idx, int az, int el);
        in_item_t r;
        r.command     = CMD_LOAD;
        r.entry_index = IDX_W'(idx);
        r.azimuth     = AZ_W'(az);
        r.elevation   = EL_W'(el);
        r.range_m     = $urandom();
        queued_requests.push_back(r);
    endfunction

    function automatic void push_test(int az, int el, logic [31:0] rng);
        in_item_t r;
        r.command     = CMD_TEST;
        r.entry_index = IDX_W'($urandom());
        r.azimuth     = AZ_W'(az);
        r.elevation   = EL_W'(el);
        r.range_m     = rng;
        queued_requests.push_back(r);
    endfunction

    // Plan and load a mask of n breakpoints; noisy gives an unsorted random table
    function automatic void load_mask(int n, bit noisy);
        int step;
        step   = FULL_TURN / (n - 1);
        plan_n = n;
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                plan_az[i] = $urandom_range(0, 131071);
                plan_el[i] = int'($urandom_range(0, 65535)) - 32768;
            end else begin
                plan_az[i] = i * FULL_TURN / (n - 1)
                             + int'($urandom_range(0, step / 2)) - step / 4;
                plan_el[i] = int'($urandom_range(0, 10000)) - 2000;
            end
        end
        if (!noisy) begin
            plan_az[0]     = 0;
            plan_az[n - 1] = FULL_TURN;
            plan_el[n - 1] = plan_el[0];
        end
        for (int i = 0; i < n; i++)
            push_load(i, plan_az[i], plan_el[i]);
    endfunction

    // Range mostly inside the interval, otherwise on or just past its bounds, or random
    function automatic logic [31:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return cur_range_min;
            1:       return cur_range_max;
            2:       return cur_range_min - 1;
            3:       return cur_range_max + 1;
            4:       return $urandom();
            default: return (cur_range_min <= cur_range_max)
                            ? $urandom_range(cur_range_max, cur_range_min) : $urandom();
        endcase
    endfunction

    initial begin
        int          n;
        int          sel;
        int          az;
        int          el;
        int          slot;
        logic [31:0] count_word;
        logic [31:0] lo_bound;
        logic [31:0] hi_bound;
        logic [31:0] a;
        logic [31:0] b;

        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        gaps_on         = 1'b1;
        mismatch_count  = 0;
        cur_range_min   = '0;
        cur_range_max   = '1;
        cur_bp_count    = 6'd2;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Flat two-entry mask, field extremes
        set_registers(32'd0, 32'hFFFF_FFFF, 32'd2);
        for (int i = 0; i < DEPTH; i++)
            push_load(i, $urandom_range(0, 131071), $urandom());
        plan_n = 2;
        plan_az[0] = 0;          plan_el[0] = 100;
        plan_az[1] = FULL_TURN;  plan_el[1] = 100;
        push_load(0, plan_az[0], plan_el[0]);
        push_load(1, plan_az[1], plan_el[1]);
        push_test(0, 100, 32'd0);
        push_test(0, 99, 32'd5);
        push_test(65535, 16384, 32'hFFFF_FFFF);
        push_test(65535, -16384, 32'd1);
        push_test(FULL_TURN, 100, 32'd7);
        push_test(131071, 100, 32'd7);
        push_test(131071, 99, 32'd7);
        push_test(32768, -32768, 32'd3);

        // Five breakpoints: exact breakpoints, midpoints, range bounds
        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        set_registers(32'd100, 32'd200, 32'd5);
        plan_az[0] = 0;      plan_el[0] = 500;
        plan_az[1] = 16384;  plan_el[1] = 2000;
        plan_az[2] = 32768;  plan_el[2] = 2000;
        plan_az[3] = 49152;  plan_el[3] = -1000;
        plan_az[4] = FULL_TURN; plan_el[4] = 500;
        for (int i = 0; i < 5; i++)
            push_load(i, plan_az[i], plan_el[i]);
        push_test(16384, 2000, 32'd150);
        push_test(16384, 1999, 32'd150);
        push_test(32768, 2000, 32'd150);
        push_test(49152, -1000, 32'd150);
        push_test(49152, -1001, 32'd150);
        push_test(8192, 1250, 32'd100);
        push_test(8192, 1249, 32'd200);
        push_test(20000, 3000, 32'd99);
        push_test(20000, 3000, 32'd201);
        push_test(0, 0, 32'd150);

        // Random phases: new settings and mask, then mostly test requests
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_requests();
            repeat (SETTLE_CYCLES) @(posedge clk);
            gaps_on = (ph < RANDOM_PHASES - 2);
            case (ph)
                0:       count_word = 32'd0;
                1:       count_word = 32'd1;
                2:       count_word = 32'd32;
                3:       count_word = 32'd63;
                4:       count_word = ($urandom() & 32'hFFFF_FFC0) | 32'd7;
                5:       count_word = 32'd3;
                6:       count_word = 32'd2;
                7:       count_word = 32'd33;
                default: count_word = $urandom_range(4, 31);
            endcase
            n = int'(count_word[COUNT_W-1:0]);
            if (n < 2)
                n = 2;
            if (n > DEPTH)
                n = DEPTH;
            a = $urandom();
            b = $urandom();
            case (ph % 6)
                1, 3: begin
                    lo_bound = (a < b) ? a : b;
                    hi_bound = (a < b) ? b : a;
                end
                4: begin
                    lo_bound = a;
                    hi_bound = (ph < 6) ? a - 1 - (b % 1000) : a;   // empty, then single value
                    if (ph < 6 && lo_bound == 0)
                        lo_bound = 1;
                    if (ph < 6)
                        hi_bound = lo_bound - 1;
                end
                5: begin
                    lo_bound = (ph < 6) ? 32'd0 : 32'hFFFF_FFFF;
                    hi_bound = lo_bound;
                end
                default: begin
                    lo_bound = 32'd0;
                    hi_bound = 32'hFFFF_FFFF;
                end
            endcase
            set_registers(lo_bound, hi_bound, count_word);
            if (ph == 5) begin
                @(posedge clk);
                write_register(CFG_UNUSED_IDX, $urandom());
                cfg_ch.valid <= 1'b0;
            end
            load_mask(n, ph % 5 == 2);

            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 8) begin
                    // rewrite a breakpoint between its neighbors, or an entry past the count
                    if (plan_n > 2 && (plan_n == DEPTH || sel < 4)) begin
                        slot = $urandom_range(1, plan_n - 2);
                        plan_az[slot] = (plan_az[slot - 1] <= plan_az[slot + 1])
                            ? $urandom_range(plan_az[slot + 1], plan_az[slot - 1])
                            : $urandom_range(0, 131071);
                        plan_el[slot] = int'($urandom_range(0, 10000)) - 2000;
                        push_load(slot, plan_az[slot], plan_el[slot]);
                    end else if (plan_n < DEPTH) begin
                        push_load($urandom_range(plan_n, DEPTH - 1),
                                  $urandom_range(0, 131071), $urandom());
                    end
                end else begin
                    if (sel < 20) begin
                        slot = $urandom_range(0, plan_n - 1);
                        az   = plan_az[slot];
                        el   = plan_el[slot] + int'($urandom_range(0, 2)) - 1;
                    end else if (sel < 26) begin
                        az = $urandom_range(0, 131071);
                        el = int'($urandom_range(0, 65535)) - 32768;
                    end else begin
                        az = $urandom_range(0, FULL_TURN - 1);
                        el = int'($urandom_range(0, 16000)) - 4000;
                    end
                    push_test(az, el, pick_range());
                end
            end
        end

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hmvc_pkg.sv
sv/hmvc_if.sv
sv/hmvc_ram.sv
sv/hmvc_mul.sv
sv/hmvc_cfg_regs.sv
sv/horizon_mask_visibility_check.sv
sv/hmvc_checker.sv
verif/horizon_mask_visibility_check_tb.sv
